FILE: sv/wge_pkg.sv
package wge_pkg;

    localparam int MAX_DIMS    = 4;
    localparam int MAX_SAMPLES = 1024;

    localparam int DIM_W   = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int DCNT_W  = $clog2(MAX_DIMS + 1);
    localparam int SMP_W   = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int NCNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int SDEPTH  = MAX_SAMPLES * MAX_DIMS;
    localparam int SADDR_W = $clog2(SDEPTH);

    localparam int VAL_W   = 32;
    localparam int RESP_W  = 17;
    localparam int WGT_W   = 17;
    localparam int MINV_W  = 31;
    localparam int DIMSR_W = 3;
    localparam int SMPR_W  = 11;
    localparam int ENT_W   = 48;
    localparam int ACC_W   = 64;
    localparam int DIVW    = NCNT_W + WGT_W;
    localparam int DCYC_W  = $clog2(ACC_W);
    localparam int IDX_W   = 2;
    localparam int CFG_W   = 31;
    localparam int CIDX_W  = 2;

    localparam logic [CIDX_W-1:0] CFG_DIMS    = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_SAMPLES = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_WEIGHT  = 2'd2;
    localparam logic [CIDX_W-1:0] CFG_MINVAR  = 2'd3;

    typedef struct packed {
        logic             wr_en;
        logic [SMP_W-1:0] wr_s;
        logic [DIM_W-1:0] wr_c;
        logic             issue;
        logic [SMP_W-1:0] k;
        logic [DIM_W-1:0] row;
        logic [DIM_W-1:0] col;
        logic             cov;
        logic             acc_clr;
        logic             div_start;
        logic             out_load;
        logic             last;
    } t_cmd;

    typedef struct packed {
        logic pipe_busy;
        logic div_done;
        logic out_free;
    } t_sts;

endpackage

FILE: sv/wge_ram.sv
module wge_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/wge_ctrl.sv
module wge_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_cfg_wr,
    input  logic [wge_pkg::DCNT_W-1:0]   i_dims,
    input  logic [wge_pkg::NCNT_W-1:0]   i_samples,
    input  wge_pkg::t_sts                i_sts,
    output wge_pkg::t_cmd                o_cmd
);

    typedef enum logic [4:0] {
        S_LOAD  = 5'b00001,
        S_ISSUE = 5'b00010,
        S_DRAIN = 5'b00100,
        S_DIV   = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic [wge_pkg::SMP_W-1:0] r_s, n_s, r_k, n_k;
    logic [wge_pkg::DIM_W-1:0] r_c, n_c, r_i, n_i, r_j, n_j;
    logic r_cov, n_cov;
    logic accept, c_last, s_last, k_last, i_last, j_last;

    assign accept = i_valid && (r_state == S_LOAD);
    assign o_stall = (r_state != S_LOAD);

    assign c_last = (wge_pkg::DCNT_W'(r_c) == i_dims - wge_pkg::DCNT_W'(1));
    assign s_last = (wge_pkg::NCNT_W'(r_s) == i_samples - wge_pkg::NCNT_W'(1));
    assign k_last = (wge_pkg::NCNT_W'(r_k) == i_samples - wge_pkg::NCNT_W'(1));
    assign i_last = (wge_pkg::DCNT_W'(r_i) == i_dims - wge_pkg::DCNT_W'(1));
    assign j_last = (wge_pkg::DCNT_W'(r_j) == i_dims - wge_pkg::DCNT_W'(1));

    always_comb begin
        n_state = r_state;
        n_s = r_s;
        n_c = r_c;
        n_k = r_k;
        n_i = r_i;
        n_j = r_j;
        n_cov = r_cov;
        o_cmd = '0;
        o_cmd.wr_s = r_s;
        o_cmd.wr_c = r_c;
        o_cmd.k = r_k;
        o_cmd.row = r_i;
        o_cmd.col = r_j;
        o_cmd.cov = r_cov;
        o_cmd.last = r_cov && i_last && j_last;
        case (r_state)
            S_LOAD: begin
                if (i_cfg_wr) begin
                    n_s = '0;
                    n_c = '0;
                end else if (accept) begin
                    o_cmd.wr_en = 1'b1;
                    if (c_last) begin
                        n_c = '0;
                        if (s_last) begin
                            n_s = '0;
                            n_k = '0;
                            n_i = '0;
                            n_j = '0;
                            n_cov = 1'b0;
                            n_state = S_ISSUE;
                        end else begin
                            n_s = r_s + 1'b1;
                        end
                    end else begin
                        n_c = r_c + 1'b1;
                    end
                end
            end
            S_ISSUE: begin
                o_cmd.issue = 1'b1;
                o_cmd.acc_clr = (r_k == '0);
                if (k_last) begin
                    n_state = S_DRAIN;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            S_DRAIN: begin
                if (!i_sts.pipe_busy) begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_k = '0;
                    n_state = S_ISSUE;
                    if (!r_cov) begin
                        if (i_last) begin
                            n_cov = 1'b1;
                            n_i = '0;
                            n_j = '0;
                        end else begin
                            n_i = r_i + 1'b1;
                        end
                    end else if (j_last) begin
                        n_j = '0;
                        if (i_last) begin
                            n_i = '0;
                            n_state = S_LOAD;
                        end else begin
                            n_i = r_i + 1'b1;
                        end
                    end else begin
                        n_j = r_j + 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_s <= '0;
            r_c <= '0;
            r_k <= '0;
            r_i <= '0;
            r_j <= '0;
            r_cov <= 1'b0;
        end else begin
            r_state <= n_state;
            r_s <= n_s;
            r_c <= n_c;
            r_k <= n_k;
            r_i <= n_i;
            r_j <= n_j;
            r_cov <= n_cov;
        end
    end

endmodule

FILE: sv/wge_dp.sv
module wge_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic signed [wge_pkg::VAL_W-1:0]  i_sample_value,
    input  logic [wge_pkg::RESP_W-1:0]        i_responsibility,
    input  logic [wge_pkg::NCNT_W-1:0]        i_samples,
    input  logic [wge_pkg::WGT_W-1:0]         i_weight,
    input  logic [wge_pkg::MINV_W-1:0]        i_min_var,
    input  logic                              i_stall,
    input  wge_pkg::t_cmd                     i_cmd,
    output wge_pkg::t_sts                     o_sts,
    output logic                              o_valid,
    output logic                              o_is_cov,
    output logic [wge_pkg::DIM_W-1:0]         o_row,
    output logic [wge_pkg::DIM_W-1:0]         o_col,
    output logic signed [wge_pkg::ENT_W-1:0]  o_value,
    output logic                              o_last
);

    localparam int SA = wge_pkg::SADDR_W;
    localparam logic signed [wge_pkg::ACC_W-1:0] ACC_MAX = {1'b0, {(wge_pkg::ACC_W-1){1'b1}}};
    localparam logic signed [wge_pkg::ACC_W-1:0] ACC_MIN = {1'b1, {(wge_pkg::ACC_W-1){1'b0}}};
    localparam logic signed [wge_pkg::ENT_W-1:0] ENT_MAX = {1'b0, {(wge_pkg::ENT_W-1){1'b1}}};
    localparam logic signed [wge_pkg::ENT_W-1:0] ENT_MIN = {1'b1, {(wge_pkg::ENT_W-1){1'b0}}};

    logic [SA-1:0] waddr, raddr_a, raddr_b;
    logic [wge_pkg::VAL_W-1:0] rd_a, rd_b;
    logic [wge_pkg::WGT_W-1:0] rd_w;

    assign waddr   = SA'(i_cmd.wr_s) * SA'(wge_pkg::MAX_DIMS) + SA'(i_cmd.wr_c);
    assign raddr_a = SA'(i_cmd.k) * SA'(wge_pkg::MAX_DIMS) + SA'(i_cmd.row);
    assign raddr_b = SA'(i_cmd.k) * SA'(wge_pkg::MAX_DIMS) + SA'(i_cmd.col);

    // Two identical copies of the sample store give two reads per cycle.
    wge_ram #(.WIDTH(wge_pkg::VAL_W), .DEPTH(wge_pkg::SDEPTH)) u_ram_a (
        .i_clk(i_clk), .i_we(i_cmd.wr_en), .i_waddr(waddr),
        .i_wdata(i_sample_value), .i_raddr(raddr_a), .o_rdata(rd_a)
    );
    wge_ram #(.WIDTH(wge_pkg::VAL_W), .DEPTH(wge_pkg::SDEPTH)) u_ram_b (
        .i_clk(i_clk), .i_we(i_cmd.wr_en), .i_waddr(waddr),
        .i_wdata(i_sample_value), .i_raddr(raddr_b), .o_rdata(rd_b)
    );
    wge_ram #(.WIDTH(wge_pkg::WGT_W), .DEPTH(wge_pkg::MAX_SAMPLES)) u_ram_w (
        .i_clk(i_clk), .i_we(i_cmd.wr_en), .i_waddr(i_cmd.wr_s),
        .i_wdata(i_responsibility), .i_raddr(i_cmd.k), .o_rdata(rd_w)
    );

    localparam int DIVW_L = wge_pkg::DIVW;
    logic signed [wge_pkg::VAL_W-1:0] r_mean [wge_pkg::MAX_DIMS];
    logic signed [wge_pkg::VAL_W-1:0] r_mu_i, r_mu_j;
    logic [DIVW_L-1:0] r_div;

    always_ff @(posedge i_clk) begin
        r_mu_i <= r_mean[i_cmd.row];
        r_mu_j <= r_mean[i_cmd.col];
        r_div  <= DIVW_L'(i_samples) * DIVW_L'(i_weight);
    end

    // term pipeline
    logic r_v1, r_v2, r_v3, r_v4;
    logic signed [wge_pkg::VAL_W:0] r_di, r_dj;
    logic [wge_pkg::WGT_W-1:0] r_w2, r_w3;
    logic [wge_pkg::ACC_W-1:0] r_prod, r_term;
    logic r_neg3, r_neg4;
    logic signed [wge_pkg::VAL_W:0] di, dj;
    logic [wge_pkg::VAL_W-1:0] mag_i, mag_j;
    logic signed [wge_pkg::ACC_W-1:0] r_acc;
    logic signed [wge_pkg::ACC_W+1:0] sum, term_s;

    always_comb begin
        di = $signed({rd_a[wge_pkg::VAL_W-1], rd_a})
             - (i_cmd.cov ? $signed({r_mu_i[wge_pkg::VAL_W-1], r_mu_i}) : '0);
        dj = i_cmd.cov ? $signed({rd_b[wge_pkg::VAL_W-1], rd_b})
                         - $signed({r_mu_j[wge_pkg::VAL_W-1], r_mu_j})
                       : (wge_pkg::VAL_W+1)'(65536);
        mag_i = r_di[wge_pkg::VAL_W] ? wge_pkg::VAL_W'(-r_di) : wge_pkg::VAL_W'(r_di);
        mag_j = r_dj[wge_pkg::VAL_W] ? wge_pkg::VAL_W'(-r_dj) : wge_pkg::VAL_W'(r_dj);
        term_s = r_neg4 ? -$signed({2'b00, r_term}) : $signed({2'b00, r_term});
        sum = $signed({{2{r_acc[wge_pkg::ACC_W-1]}}, r_acc}) + term_s;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_acc <= '0;
        end else begin
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            if (i_cmd.acc_clr) begin
                r_acc <= '0;
            end else if (r_v4) begin
                if (sum > $signed({{2{1'b0}}, ACC_MAX})) begin
                    r_acc <= ACC_MAX;
                end else if (sum < $signed({{2{1'b1}}, ACC_MIN})) begin
                    r_acc <= ACC_MIN;
                end else begin
                    r_acc <= sum[wge_pkg::ACC_W-1:0];
                end
            end
        end
        r_di <= di;
        r_dj <= dj;
        r_w2 <= rd_w;
        r_prod <= mag_i * mag_j;
        r_neg3 <= r_di[wge_pkg::VAL_W] ^ r_dj[wge_pkg::VAL_W];
        r_w3 <= r_w2;
        r_term <= wge_pkg::ACC_W'(r_prod[wge_pkg::ACC_W-1:16]) * wge_pkg::ACC_W'(r_w3);
        r_neg4 <= r_neg3;
    end

    // restoring divider, one quotient bit per cycle
    logic r_run;
    logic [wge_pkg::DCYC_W-1:0] r_cnt;
    logic [DIVW_L-1:0] r_rem;
    logic [wge_pkg::ACC_W-1:0] r_quo;
    logic [DIVW_L:0] trial;
    logic fits;

    assign trial = {r_rem, r_quo[wge_pkg::ACC_W-1]};
    assign fits  = (trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_cnt <= '0;
        end else if (i_cmd.div_start) begin
            r_run <= 1'b1;
            r_cnt <= '0;
        end else if (r_run) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == {wge_pkg::DCYC_W{1'b1}}) begin
                r_run <= 1'b0;
            end
        end
        if (i_cmd.div_start) begin
            r_rem <= '0;
            r_quo <= r_acc[wge_pkg::ACC_W-1] ? wge_pkg::ACC_W'(-r_acc)
                                             : wge_pkg::ACC_W'(r_acc);
        end else if (r_run) begin
            r_rem <= fits ? DIVW_L'(trial - {1'b0, r_div}) : trial[DIVW_L-1:0];
            r_quo <= {r_quo[wge_pkg::ACC_W-2:0], fits};
        end
    end

    logic signed [wge_pkg::ENT_W-1:0] qval, result;
    logic signed [wge_pkg::VAL_W-1:0] mean_sat;
    logic acc_neg;

    assign acc_neg = r_acc[wge_pkg::ACC_W-1];

    always_comb begin
        if (r_div == '0) begin
            qval = acc_neg ? ENT_MIN : ((r_acc != '0) ? ENT_MAX : '0);
        end else if (acc_neg) begin
            qval = (r_quo > wge_pkg::ACC_W'(ENT_MAX) + 1'b1) ? ENT_MIN
                 : -$signed(r_quo[wge_pkg::ENT_W-1:0]);
        end else begin
            qval = (r_quo > wge_pkg::ACC_W'(ENT_MAX)) ? ENT_MAX
                 : $signed(r_quo[wge_pkg::ENT_W-1:0]);
        end
        result = qval;
        if (i_cmd.cov && (i_cmd.row == i_cmd.col)
            && (qval < $signed({{(wge_pkg::ENT_W-wge_pkg::MINV_W){1'b0}}, i_min_var}))) begin
            result = $signed({{(wge_pkg::ENT_W-wge_pkg::MINV_W){1'b0}}, i_min_var});
        end
        if (qval > $signed(wge_pkg::ENT_W'(32'sh7FFF_FFFF))) begin
            mean_sat = {1'b0, {(wge_pkg::VAL_W-1){1'b1}}};
        end else if (qval < -$signed(wge_pkg::ENT_W'(33'sh0_8000_0000))) begin
            mean_sat = {1'b1, {(wge_pkg::VAL_W-1){1'b0}}};
        end else begin
            mean_sat = qval[wge_pkg::VAL_W-1:0];
        end
    end

    // output register
    logic r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            for (int m = 0; m < wge_pkg::MAX_DIMS; m++) begin
                r_mean[m] <= '0;
            end
        end else begin
            if (i_cmd.out_load) begin
                r_valid <= 1'b1;
                if (!i_cmd.cov) begin
                    r_mean[i_cmd.row] <= mean_sat;
                end
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
        if (i_cmd.out_load) begin
            o_is_cov <= i_cmd.cov;
            o_row <= i_cmd.row;
            o_col <= i_cmd.cov ? i_cmd.col : '0;
            o_value <= result;
            o_last <= i_cmd.last;
        end
    end

    assign o_valid = r_valid;
    assign o_sts.pipe_busy = r_v1 | r_v2 | r_v3 | r_v4;
    assign o_sts.div_done  = !r_run;
    assign o_sts.out_free  = !r_valid || !i_stall;

endmodule

FILE: sv/weighted_gaussian_estimator.sv
// Channel   Direction  Handshake              Payload
// input     in         i_valid / o_stall      i_sample_value, i_responsibility
// output    out        o_valid / i_stall      o_is_covariance, o_row_index, o_col_index,
//                                             o_entry_value, o_last_entry
// config    in         i_cfg_wr_en            i_cfg_index, i_cfg_data
//
// Loading takes one item per cycle, D*N items per set.
// The set then costs (D + D*D) entries, each passing through sample store reads, a term
// pipeline and a radix-2 divider.
// Reset is synchronous and active low; no clearing pass, the stores are not cleared.
// A stalled output holds its entry; the next entry waits in the divider.
module weighted_gaussian_estimator (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic signed [wge_pkg::VAL_W-1:0]  i_sample_value,
    input  logic [wge_pkg::RESP_W-1:0]        i_responsibility,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic                              o_is_covariance,
    output logic [wge_pkg::IDX_W-1:0]         o_row_index,
    output logic [wge_pkg::IDX_W-1:0]         o_col_index,
    output logic signed [wge_pkg::ENT_W-1:0]  o_entry_value,
    output logic                              o_last_entry,
    input  logic                              i_cfg_wr_en,
    input  logic [wge_pkg::CIDX_W-1:0]        i_cfg_index,
    input  logic [wge_pkg::CFG_W-1:0]         i_cfg_data
);

    logic [wge_pkg::DIMSR_W-1:0] r_dims;
    logic [wge_pkg::SMPR_W-1:0]  r_samples;
    logic [wge_pkg::WGT_W-1:0]   r_weight;
    logic [wge_pkg::MINV_W-1:0]  r_min_var;

    // Register writes; a write while loading restarts loading in the controller.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dims    <= wge_pkg::DIMSR_W'(wge_pkg::MAX_DIMS);
            r_samples <= wge_pkg::SMPR_W'(wge_pkg::MAX_SAMPLES);
            r_weight  <= wge_pkg::WGT_W'(65536);
            r_min_var <= wge_pkg::MINV_W'(1);
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                wge_pkg::CFG_DIMS:    r_dims    <= i_cfg_data[wge_pkg::DIMSR_W-1:0];
                wge_pkg::CFG_SAMPLES: r_samples <= i_cfg_data[wge_pkg::SMPR_W-1:0];
                wge_pkg::CFG_WEIGHT:  r_weight  <= i_cfg_data[wge_pkg::WGT_W-1:0];
                wge_pkg::CFG_MINVAR:  r_min_var <= i_cfg_data[wge_pkg::MINV_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Clamp counts into range: zero acts as one, too large acts as the maximum.
    logic [wge_pkg::DCNT_W-1:0] eff_dims;
    logic [wge_pkg::NCNT_W-1:0] eff_samples;
    logic cfg_wr;

    always_comb begin
        if (r_dims == '0) begin
            eff_dims = wge_pkg::DCNT_W'(1);
        end else if (32'(r_dims) > wge_pkg::MAX_DIMS) begin
            eff_dims = wge_pkg::DCNT_W'(wge_pkg::MAX_DIMS);
        end else begin
            eff_dims = wge_pkg::DCNT_W'(r_dims);
        end
        if (r_samples == '0) begin
            eff_samples = wge_pkg::NCNT_W'(1);
        end else if (32'(r_samples) > wge_pkg::MAX_SAMPLES) begin
            eff_samples = wge_pkg::NCNT_W'(wge_pkg::MAX_SAMPLES);
        end else begin
            eff_samples = wge_pkg::NCNT_W'(r_samples);
        end
    end

    assign cfg_wr = i_cfg_wr_en;

    wge_pkg::t_cmd cmd;
    wge_pkg::t_sts sts;
    logic [wge_pkg::DIM_W-1:0] row, col;

    wge_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_cfg_wr(cfg_wr),
        .i_dims(eff_dims), .i_samples(eff_samples),
        .i_sts(sts), .o_cmd(cmd)
    );

    wge_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_sample_value(i_sample_value), .i_responsibility(i_responsibility),
        .i_samples(eff_samples), .i_weight(r_weight), .i_min_var(r_min_var),
        .i_stall(i_stall), .i_cmd(cmd), .o_sts(sts),
        .o_valid(o_valid), .o_is_cov(o_is_covariance),
        .o_row(row), .o_col(col),
        .o_value(o_entry_value), .o_last(o_last_entry)
    );

    assign o_row_index = wge_pkg::IDX_W'(row);
    assign o_col_index = wge_pkg::IDX_W'(col);

endmodule

FILE: sv/wge_checker.sv
module wge_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_valid,
    input logic                              o_stall,
    input logic signed [wge_pkg::VAL_W-1:0]  i_sample_value,
    input logic [wge_pkg::RESP_W-1:0]        i_responsibility,
    input logic                              o_valid,
    input logic                              i_stall,
    input logic                              o_is_covariance,
    input logic [wge_pkg::IDX_W-1:0]         o_row_index,
    input logic [wge_pkg::IDX_W-1:0]         o_col_index,
    input logic signed [wge_pkg::ENT_W-1:0]  o_entry_value,
    input logic                              o_last_entry,
    input logic                              i_cfg_wr_en,
    input logic [wge_pkg::CIDX_W-1:0]        i_cfg_index,
    input logic [wge_pkg::CFG_W-1:0]         i_cfg_data
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_entry_value))
        else $error("stalled entry changed");

    a_mean_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_is_covariance |-> o_col_index == '0)
        else $error("mean entry with nonzero column");

    a_last_cov: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_entry |-> o_is_covariance && o_row_index == o_col_index)
        else $error("last flag off the final diagonal");

    a_diag_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_covariance && o_row_index == o_col_index |-> !o_entry_value[47])
        else $error("negative variance");

endmodule

bind weighted_gaussian_estimator wge_checker u_wge_checker (.*);
